>>> hdl/sip_pkg.sv
// Shared types, constants and arithmetic helpers for the segment intersection block.
// Depends on nothing; used by hdl/segment_intersection_params.sv.
`default_nettype none
package sip_pkg;

	// Default number of fraction bits in the reported parameters.
	localparam int PARAM_FRAC_BITS_DEF = 30;
	// Quotient bits produced by the divider lanes, one bit per stage.
	localparam int QBITS = 32;
	// Reset value of the domain scale register (1.0 in Q16.16).
	localparam logic [30:0] DS_RESET = 31'd65536;
	// Reset value of the squared scale (DS_RESET squared).
	localparam logic [61:0] W0SQ_RESET = 62'h1_0000_0000;
	// Reciprocal of the determinant tolerance, 1e9.
	localparam logic [29:0] DET_RECIP = 30'd1000000000;
	// Range limits scaled by 1e7: the reciprocal of the lower margin and one plus the upper margin.
	localparam logic [23:0] RANGE_LO = 24'd10000000;
	localparam logic [23:0] RANGE_HI = 24'd10000001;

	// Relation codes reported with every result.
	typedef enum logic [1:0] {
		REL_GENERAL   = 2'd0,
		REL_PARALLEL  = 2'd1,
		REL_COLLINEAR = 2'd2
	} relation_t;

	// One restoring divider lane: partial remainder, dividend bits still to enter, quotient.
	typedef struct packed {
		logic [63:0] r;
		logic [31:0] lo;
		logic [31:0] q;
	} div_lane_t;

	// Everything that travels down the divider stages with an item.
	typedef struct packed {
		relation_t   rel;
		logic        fault;
		logic        neg1;
		logic        neg2;
		logic        ov1;
		logic        ov2;
		logic        in1;
		logic        in2;
		logic [63:0] ud;
		div_lane_t   lane1;
		div_lane_t   lane2;
	} sip_tail_t;

	// Magnitude of a signed 32-bit word as an unsigned word.
	function automatic logic [31:0] mag32(logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// Magnitude of a signed 64-bit word as an unsigned word.
	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	// One step of restoring division: bring in the next dividend bit, subtract if it fits.
	function automatic div_lane_t div_step(div_lane_t l, logic [63:0] ud);
		logic [64:0] rs;
		div_lane_t n;
		rs = {l.r, l.lo[31]};
		n = l;
		n.lo = {l.lo[30:0], 1'b0};
		if (rs >= {1'b0, ud}) begin
			rs = rs - {1'b0, ud};
			n.q = {l.q[30:0], 1'b1};
		end else begin
			n.q = {l.q[30:0], 1'b0};
		end
		n.r = rs[63:0];
		return n;
	endfunction

	// Apply the sign and saturate the quotient to the 32-bit signed range.
	function automatic logic [31:0] sat_param(logic [31:0] q, logic ov, logic neg);
		logic [31:0] m;
		if (neg) begin
			m = (ov || q > 32'h8000_0000) ? 32'h8000_0000 : q;
			return 32'd0 - m;
		end
		return (ov || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
	endfunction

endpackage
`default_nettype wire

>>> hdl/segment_intersection_params.sv
// Pipelined planar segment intersection: determinants, tolerance tests and two divider lanes.
// Depends on hdl/sip_pkg.sv for types, constants and arithmetic helpers.
// One item may start in every cycle; the pipeline is made of the nine arithmetic stages,
// the 32 one-bit divider stages and the output register.
// busy is never raised, and the receiver cannot stall the pipeline.
// Reset clears every valid bit and returns domain_scale to 1.0 (65536).
`default_nettype none
module segment_intersection_params #(
	parameter int PARAM_FRAC_BITS = sip_pkg::PARAM_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output      logic               busy,
	input  wire logic               cfg_wr_en,
	input  wire logic        [30:0] cfg_wr_data,
	input  wire logic signed [31:0] dx_p2_p1,
	input  wire logic signed [31:0] dx_p3_p1,
	input  wire logic signed [31:0] dx_p3_p4,
	input  wire logic signed [31:0] dx_p4_p1,
	input  wire logic signed [31:0] dy_p2_p1,
	input  wire logic signed [31:0] dy_p3_p1,
	input  wire logic signed [31:0] dy_p3_p4,
	input  wire logic signed [31:0] dy_p4_p1,
	output      logic               done,
	output      logic               hit,
	output      logic signed [31:0] t_first,
	output      logic signed [31:0] t_second,
	output      logic        [1:0]  relation,
	output      logic               divide_fault
);

	localparam int SH = 32 - PARAM_FRAC_BITS;
	localparam int QB = sip_pkg::QBITS;
	localparam int LATENCY = 10 + QB;

	// Configuration register and its square, which sets the determinant tolerance.
	logic [30:0] ds_q;
	logic [61:0] w0sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ds_q   <= sip_pkg::DS_RESET;
			w0sq_q <= sip_pkg::W0SQ_RESET;
		end else begin
			if (cfg_wr_en) begin
				ds_q <= cfg_wr_data;
			end
			w0sq_q <= 62'(ds_q) * 62'(ds_q);
		end
	end

	// Valid bits for every stage.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic div_v [0:QB];
	logic done_q;

	// Stage 1: the six cross products.
	logic signed [63:0] pa_s1, pb_s1, pc_s1, pd_s1, pe_s1, pf_s1;
	logic signed [31:0] x21_s1, y21_s1, x31_s1, y31_s1, x41_s1, y41_s1;

	// Stage 2: determinants and the collinear operands on the dominant axis.
	logic signed [63:0] d0_s2, d1_s2, d2_s2;
	logic signed [31:0] a_s2, b3_s2, b4_s2;

	// Stage 3: magnitudes and signs.
	logic [63:0] md0_s3, md1_s3, md2_s3;
	logic        sd0_s3, sd1_s3, sd2_s3;
	logic [31:0] ma_s3, mb3_s3, mb4_s3;
	logic        sa_s3, sb3_s3, sb4_s3;

	// Stage 4: tolerance partial products; operands carried along.
	logic [61:0] pp0lo_s4, pp0hi_s4, pp1lo_s4, pp1hi_s4;
	logic [63:0] md0_s4, md1_s4, md2_s4;
	logic        sd0_s4, sd1_s4, sd2_s4;
	logic [31:0] ma_s4, mb3_s4, mb4_s4;
	logic        sa_s4, sb3_s4, sb4_s4;

	// Stage 5: scaled determinant magnitudes.
	logic [93:0] ps0_s5, ps1_s5;
	logic [63:0] md0_s5, md1_s5, md2_s5;
	logic        sd0_s5, sd1_s5, sd2_s5;
	logic [31:0] ma_s5, mb3_s5, mb4_s5;
	logic        sa_s5, sb3_s5, sb4_s5;

	// Stage 6: classification and divider operands.
	sip_pkg::relation_t rel_s6;
	logic        fault_s6, neg1_s6, neg2_s6;
	logic [63:0] un1_s6, un2_s6, ud_s6;

	// Stage 7: range partial products.
	logic [55:0] r1lo_s7, r1hi_s7, r2lo_s7, r2hi_s7, rblo_s7, rbhi_s7;
	sip_pkg::relation_t rel_s7;
	logic        fault_s7, neg1_s7, neg2_s7;
	logic [63:0] un1_s7, un2_s7, ud_s7;

	// Stage 8: scaled numerators and scaled divisor.
	logic [87:0] ra1_s8, ra2_s8, rb_s8;
	sip_pkg::relation_t rel_s8;
	logic        fault_s8, neg1_s8, neg2_s8;
	logic [63:0] un1_s8, un2_s8, ud_s8;

	// Divider stages; entry zero is loaded with the range results and initial remainders.
	sip_pkg::sip_tail_t div_s [0:QB];

	// Output registers.
	logic        hit_q, fault_q;
	logic [31:0] t1_q, t2_q;
	logic [1:0]  rel_q;

	// Valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			div_v[0] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			div_v[0] <= v_s8;
			done_q <= div_v[QB];
		end
	end

	// Stages one to five: products, determinants, magnitudes and tolerance scaling.
	always_ff @(posedge clk) begin
		pa_s1  <= 64'(dx_p2_p1) * 64'(dy_p3_p4);
		pb_s1  <= 64'(dx_p3_p4) * 64'(dy_p2_p1);
		pc_s1  <= 64'(dx_p3_p1) * 64'(dy_p3_p4);
		pd_s1  <= 64'(dx_p3_p4) * 64'(dy_p3_p1);
		pe_s1  <= 64'(dx_p2_p1) * 64'(dy_p3_p1);
		pf_s1  <= 64'(dx_p3_p1) * 64'(dy_p2_p1);
		x21_s1 <= dx_p2_p1;
		y21_s1 <= dy_p2_p1;
		x31_s1 <= dx_p3_p1;
		y31_s1 <= dy_p3_p1;
		x41_s1 <= dx_p4_p1;
		y41_s1 <= dy_p4_p1;

		d0_s2 <= pa_s1 - pb_s1;
		d1_s2 <= pc_s1 - pd_s1;
		d2_s2 <= pe_s1 - pf_s1;
		if (sip_pkg::mag32(x21_s1) > sip_pkg::mag32(y21_s1)) begin
			a_s2  <= x21_s1;
			b3_s2 <= x31_s1;
			b4_s2 <= x41_s1;
		end else begin
			a_s2  <= y21_s1;
			b3_s2 <= y31_s1;
			b4_s2 <= y41_s1;
		end

		md0_s3 <= sip_pkg::mag64(d0_s2);
		md1_s3 <= sip_pkg::mag64(d1_s2);
		md2_s3 <= sip_pkg::mag64(d2_s2);
		sd0_s3 <= d0_s2[63];
		sd1_s3 <= d1_s2[63];
		sd2_s3 <= d2_s2[63];
		ma_s3  <= sip_pkg::mag32(a_s2);
		mb3_s3 <= sip_pkg::mag32(b3_s2);
		mb4_s3 <= sip_pkg::mag32(b4_s2);
		sa_s3  <= a_s2[31];
		sb3_s3 <= b3_s2[31];
		sb4_s3 <= b4_s2[31];

		pp0lo_s4 <= 62'(md0_s3[31:0]) * 62'(sip_pkg::DET_RECIP);
		pp0hi_s4 <= 62'(md0_s3[63:32]) * 62'(sip_pkg::DET_RECIP);
		pp1lo_s4 <= 62'(md1_s3[31:0]) * 62'(sip_pkg::DET_RECIP);
		pp1hi_s4 <= 62'(md1_s3[63:32]) * 62'(sip_pkg::DET_RECIP);
		md0_s4 <= md0_s3;
		md1_s4 <= md1_s3;
		md2_s4 <= md2_s3;
		sd0_s4 <= sd0_s3;
		sd1_s4 <= sd1_s3;
		sd2_s4 <= sd2_s3;
		ma_s4  <= ma_s3;
		mb3_s4 <= mb3_s3;
		mb4_s4 <= mb4_s3;
		sa_s4  <= sa_s3;
		sb3_s4 <= sb3_s3;
		sb4_s4 <= sb4_s3;

		ps0_s5 <= {pp0hi_s4, 32'd0} + {32'd0, pp0lo_s4};
		ps1_s5 <= {pp1hi_s4, 32'd0} + {32'd0, pp1lo_s4};
		md0_s5 <= md0_s4;
		md1_s5 <= md1_s4;
		md2_s5 <= md2_s4;
		sd0_s5 <= sd0_s4;
		sd1_s5 <= sd1_s4;
		sd2_s5 <= sd2_s4;
		ma_s5  <= ma_s4;
		mb3_s5 <= mb3_s4;
		mb4_s5 <= mb4_s4;
		sa_s5  <= sa_s4;
		sb3_s5 <= sb3_s4;
		sb4_s5 <= sb4_s4;
	end

	// Tolerance tests ahead of stage six.
	logic z0, z1;
	assign z0 = ps0_s5 < {32'd0, w0sq_q};
	assign z1 = ps1_s5 < {32'd0, w0sq_q};

	// Stages six to eight: classification, range scaling and sums.
	always_ff @(posedge clk) begin
		if (z0 && z1) begin
			rel_s6   <= sip_pkg::REL_COLLINEAR;
			fault_s6 <= (ma_s5 == 32'd0);
			un1_s6   <= {32'd0, mb3_s5};
			un2_s6   <= {32'd0, mb4_s5};
			ud_s6    <= {32'd0, ma_s5};
			neg1_s6  <= sb3_s5 ^ sa_s5;
			neg2_s6  <= sb4_s5 ^ sa_s5;
		end else begin
			rel_s6   <= z0 ? sip_pkg::REL_PARALLEL : sip_pkg::REL_GENERAL;
			fault_s6 <= !z0 && (md0_s5 == 64'd0);
			un1_s6   <= md1_s5;
			un2_s6   <= md2_s5;
			ud_s6    <= md0_s5;
			neg1_s6  <= sd1_s5 ^ sd0_s5;
			neg2_s6  <= sd2_s5 ^ sd0_s5;
		end

		r1lo_s7  <= 56'(un1_s6[31:0]) * 56'(sip_pkg::RANGE_LO);
		r1hi_s7  <= 56'(un1_s6[63:32]) * 56'(sip_pkg::RANGE_LO);
		r2lo_s7  <= 56'(un2_s6[31:0]) * 56'(sip_pkg::RANGE_LO);
		r2hi_s7  <= 56'(un2_s6[63:32]) * 56'(sip_pkg::RANGE_LO);
		rblo_s7  <= 56'(ud_s6[31:0]) * 56'(sip_pkg::RANGE_HI);
		rbhi_s7  <= 56'(ud_s6[63:32]) * 56'(sip_pkg::RANGE_HI);
		rel_s7   <= rel_s6;
		fault_s7 <= fault_s6;
		neg1_s7  <= neg1_s6;
		neg2_s7  <= neg2_s6;
		un1_s7   <= un1_s6;
		un2_s7   <= un2_s6;
		ud_s7    <= ud_s6;

		ra1_s8   <= {r1hi_s7, 32'd0} + {32'd0, r1lo_s7};
		ra2_s8   <= {r2hi_s7, 32'd0} + {32'd0, r2lo_s7};
		rb_s8    <= {rbhi_s7, 32'd0} + {32'd0, rblo_s7};
		rel_s8   <= rel_s7;
		fault_s8 <= fault_s7;
		neg1_s8  <= neg1_s7;
		neg2_s8  <= neg2_s7;
		un1_s8   <= un1_s7;
		un2_s8   <= un2_s7;
		ud_s8    <= ud_s7;
	end

	// Range decisions, overflow checks and divider set-up for the first divider stage.
	logic                out1, out2;
	sip_pkg::sip_tail_t  head;

	always_comb begin
		out1 = (un1_s8 != 64'd0) &&
			(neg1_s8 ? (ra1_s8 > {24'd0, ud_s8}) : (ra1_s8 > rb_s8));
		out2 = (un2_s8 != 64'd0) &&
			(neg2_s8 ? (ra2_s8 > {24'd0, ud_s8}) : (ra2_s8 > rb_s8));
		head.rel   = rel_s8;
		head.fault = fault_s8;
		head.neg1  = neg1_s8;
		head.neg2  = neg2_s8;
		head.in1   = !out1;
		head.in2   = !out2;
		head.ud    = ud_s8;
		head.ov1   = {{SH{1'b0}}, un1_s8} >= {ud_s8, {SH{1'b0}}};
		head.ov2   = {{SH{1'b0}}, un2_s8} >= {ud_s8, {SH{1'b0}}};
		head.lane1.r  = 64'(un1_s8 >> SH);
		head.lane1.lo = {un1_s8[SH-1:0], {PARAM_FRAC_BITS{1'b0}}};
		head.lane1.q  = 32'd0;
		head.lane2.r  = 64'(un2_s8 >> SH);
		head.lane2.lo = {un2_s8[SH-1:0], {PARAM_FRAC_BITS{1'b0}}};
		head.lane2.q  = 32'd0;
	end

	always_ff @(posedge clk) begin
		div_s[0] <= head;
	end

	// Divider stages: one quotient bit per lane per stage.
	for (genvar k = 0; k < QB; k++) begin : g_div
		sip_pkg::sip_tail_t nxt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[k+1] <= 1'b0;
			end else begin
				div_v[k+1] <= div_v[k];
			end
		end

		// The word moves on unchanged apart from the two lanes.
		always_comb begin
			nxt       = div_s[k];
			nxt.lane1 = sip_pkg::div_step(div_s[k].lane1, div_s[k].ud);
			nxt.lane2 = sip_pkg::div_step(div_s[k].lane2, div_s[k].ud);
		end

		always_ff @(posedge clk) begin
			div_s[k+1] <= nxt;
		end
	end

	// Result assembly from the last divider stage.
	sip_pkg::sip_tail_t tl;
	logic [31:0] q1, q2, t1_d, t2_d;
	logic        hit_d;

	always_comb begin
		tl    = div_s[QB];
		q1    = sip_pkg::sat_param(tl.lane1.q, tl.ov1, tl.neg1);
		q2    = sip_pkg::sat_param(tl.lane2.q, tl.ov2, tl.neg2);
		t1_d  = 32'd0;
		t2_d  = 32'd0;
		hit_d = 1'b0;
		case (tl.rel)
			sip_pkg::REL_COLLINEAR: begin
				if (!tl.fault) begin
					hit_d = tl.in1 ^ tl.in2;
					if (tl.in2) begin
						t1_d = q2;
						t2_d = 32'd1 << PARAM_FRAC_BITS;
					end else begin
						t1_d = q1;
					end
				end
			end
			sip_pkg::REL_GENERAL: begin
				if (!tl.fault) begin
					t1_d = q1;
					if (tl.in1) begin
						t2_d  = q2;
						hit_d = tl.in2;
					end
				end
			end
			default: begin
				t1_d  = 32'd0;
				t2_d  = 32'd0;
				hit_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		hit_q   <= hit_d;
		t1_q    <= t1_d;
		t2_q    <= t2_d;
		rel_q   <= tl.rel;
		fault_q <= tl.fault;
	end

	assign busy         = 1'b0;
	assign done         = done_q;
	assign hit          = hit_q;
	assign t_first      = t1_q;
	assign t_second     = t2_q;
	assign relation     = rel_q;
	assign divide_fault = fault_q;

	// Every accepted word leaves after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("result word missing after pipeline latency");

	// A zero divisor must report a miss with cleared parameters.
	a_fault_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_fault |-> !hit && t_first == 32'sd0 && t_second == 32'sd0)
		else $error("faulted word carries a hit or parameters");

	// Parallel segments never hit and carry no parameters or fault.
	a_parallel: assert property (@(posedge clk) disable iff (!arst_n)
		done && relation == sip_pkg::REL_PARALLEL |->
			!hit && !divide_fault && t_first == 32'sd0 && t_second == 32'sd0)
		else $error("parallel word carries a hit, fault or parameters");

endmodule
`default_nettype wire

>>> tb/segment_intersection_params_tb.sv
// Self-checking testbench for the segment intersection block: directed and random segment pairs.
// Depends on hdl/sip_pkg.sv and hdl/segment_intersection_params.sv; needs nothing else.
`default_nettype none
module segment_intersection_params_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PF = sip_pkg::PARAM_FRAC_BITS_DEF;
	localparam longint UNIT = 65536;
	localparam int SETTLE_CYCLES = 48;
	localparam int CYCLE_LIMIT = 200000;

	// One segment pair as the block sees it.
	typedef struct packed {
		logic signed [31:0] x21, x31, x34, x41;
		logic signed [31:0] y21, y31, y34, y41;
	} seg_pair_t;

	// One predicted result word.
	typedef struct packed {
		logic               hit;
		logic [31:0]        t1;
		logic [31:0]        t2;
		sip_pkg::relation_t rel;
		logic               fault;
	} crossing_t;

	typedef enum logic [1:0] {ITEM_PAIR, ITEM_SCALE, ITEM_DRAIN} work_kind_t;

	typedef struct {
		work_kind_t  kind;
		seg_pair_t   pair;
		logic [30:0] scale;
	} work_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [30:0] cfg_wr_data = '0;
	seg_pair_t   pair_q = '0;
	logic        busy, done, hit, divide_fault;
	logic signed [31:0] t_first, t_second;
	logic [1:0]  relation;

	work_t      work_queue[$];
	crossing_t  expected_words[$];
	crossing_t  staged_word;
	crossing_t  head_word;
	logic [30:0] scale_now = sip_pkg::DS_RESET;
	int gap = 0;
	int calm = 0;
	int settle = 0;
	int errors = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_scales = 0;
	int n_hits = 0;
	int cycles = 0;

	segment_intersection_params dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.dx_p2_p1(pair_q.x21), .dx_p3_p1(pair_q.x31), .dx_p3_p4(pair_q.x34),
		.dx_p4_p1(pair_q.x41), .dy_p2_p1(pair_q.y21), .dy_p3_p1(pair_q.y31),
		.dy_p3_p4(pair_q.y34), .dy_p4_p1(pair_q.y41),
		.done(done), .hit(hit), .t_first(t_first), .t_second(t_second),
		.relation(relation), .divide_fault(divide_fault)
	);

	always #1 clk = ~clk;

	// Magnitude of a signed 64-bit value, widened for exact products.
	function automatic logic [127:0] magnitude(longint v);
		return v < 0 ? 128'(-v) : 128'(v);
	endfunction

	// True when n/d lies outside [-1e-7, 1+1e-7], tested exactly.
	function automatic bit outside_unit(longint n, longint d);
		logic [127:0] un, ud;
		un = magnitude(n);
		ud = magnitude(d);
		if (un == 0)
			return 1'b0;
		if ((n < 0) != (d < 0))
			return un * 10000000 > ud;
		return un * 10000000 > ud * 10000001;
	endfunction

	// n/d in fixed point, truncated toward zero and saturated to 32 bits.
	function automatic logic [31:0] fixed_ratio(longint n, longint d);
		logic [127:0] q;
		q = (magnitude(n) << PF) / magnitude(d);
		if ((n < 0) != (d < 0)) begin
			if (q > 128'h8000_0000)
				q = 128'h8000_0000;
			return 32'(128'd0 - q);
		end
		return q > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
	endfunction

	// Expected result for one pair under the given domain scale.
	function automatic crossing_t predict_crossing(seg_pair_t p, logic [30:0] w0);
		longint d0, d1, d2, a, b3, b4;
		logic [127:0] w0sq;
		bit z0, z1, xaxis;
		crossing_t r;
		r = '{hit: 1'b0, t1: '0, t2: '0, rel: sip_pkg::REL_GENERAL, fault: 1'b0};
		w0sq = 128'(w0) * 128'(w0);
		d0 = longint'(p.x21) * longint'(p.y34) - longint'(p.x34) * longint'(p.y21);
		d1 = longint'(p.x31) * longint'(p.y34) - longint'(p.x34) * longint'(p.y31);
		d2 = longint'(p.x21) * longint'(p.y31) - longint'(p.x31) * longint'(p.y21);
		z0 = magnitude(d0) * 1000000000 < w0sq;
		z1 = magnitude(d1) * 1000000000 < w0sq;
		if (z0 && z1) begin
			// Collinear: measure P3 and P4 along the dominant axis of the first segment.
			xaxis = magnitude(longint'(p.x21)) > magnitude(longint'(p.y21));
			a = xaxis ? longint'(p.x21) : longint'(p.y21);
			b3 = xaxis ? longint'(p.x31) : longint'(p.y31);
			b4 = xaxis ? longint'(p.x41) : longint'(p.y41);
			r.rel = sip_pkg::REL_COLLINEAR;
			if (a == 0) begin
				r.fault = 1'b1;
			end else begin
				r.t1 = fixed_ratio(b3, a);
				r.hit = !outside_unit(b3, a);
				if (!outside_unit(b4, a)) begin
					r.t1 = fixed_ratio(b4, a);
					r.t2 = 32'(1) << PF;
					r.hit = !r.hit;
				end
			end
		end else if (z0) begin
			r.rel = sip_pkg::REL_PARALLEL;
		end else if (d0 == 0) begin
			r.fault = 1'b1;
		end else begin
			r.t1 = fixed_ratio(d1, d0);
			if (!outside_unit(d1, d0)) begin
				r.t2 = fixed_ratio(d2, d0);
				r.hit = !outside_unit(d2, d0);
			end
		end
		return r;
	endfunction

	// Pair from four points given in raw Q16.16 coordinates.
	function automatic seg_pair_t from_points(longint x1, longint y1, longint x2, longint y2,
			longint x3, longint y3, longint x4, longint y4);
		seg_pair_t p;
		p.x21 = 32'(x2 - x1); p.x31 = 32'(x3 - x1); p.x34 = 32'(x3 - x4); p.x41 = 32'(x4 - x1);
		p.y21 = 32'(y2 - y1); p.y31 = 32'(y3 - y1); p.y34 = 32'(y3 - y4); p.y41 = 32'(y4 - y1);
		return p;
	endfunction

	function automatic longint pick(longint span);
		return longint'($urandom_range(0, 32'(2 * span))) - span;
	endfunction

	task automatic push_pair(seg_pair_t p);
		work_queue.push_back('{kind: ITEM_PAIR, pair: p, scale: '0});
	endtask

	task automatic push_scale(logic [30:0] v);
		work_queue.push_back('{kind: ITEM_SCALE, pair: '0, scale: v});
	endtask

	// Hand-picked pairs: every relation, both hit outcomes, faults and field extremes.
	task automatic push_directed();
		longint u;
		u = UNIT;
		push_pair(from_points(0, 0, 2*u, 0, u, -u, u, u));
		push_pair(from_points(0, 0, 2*u, 0, 3*u, -u, 3*u, u));
		push_pair(from_points(0, 0, 2*u, 0, u, u, u, 2*u));
		push_pair(from_points(0, 0, 2*u, 0, 0, u, 2*u, u));
		push_pair(from_points(0, 0, 2*u, 0, u, 0, 5*u, 0));
		push_pair(from_points(0, 0, 2*u, 0, 5*u, 0, u, 0));
		push_pair(from_points(0, 0, 2*u, 0, u/2, 0, u, 0));
		push_pair(from_points(0, 0, 2*u, 0, -3*u, 0, -u, 0));
		push_pair(from_points(0, 0, 0, 4*u, 0, u, 0, 9*u));
		push_pair(from_points(0, 0, 0, 0, 0, 0, 0, 0));
		push_pair(from_points(0, 0, 2*u, 2*u, 2*u, 2*u, 3*u, 0));
		push_pair(from_points(0, 0, 2*u, 0, 0, -u, 2*u, 2*u));
		push_pair(from_points(0, 0, u, 0, 1000*u, -u, 1000*u + 1, u));
		push_pair(from_points(0, 0, u, 0, -1000*u, -u, -1000*u + 1, u));
		push_pair(from_points(0, 0, 2*u, 2*u, 2*u, 0, 0, 2*u));
		push_pair({8{32'h8000_0000}});
		push_pair({8{32'h7FFF_FFFF}});
		push_pair({4{32'hAAAA_AAAA, 32'h5555_5555}});
		push_pair({32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001});
	endtask

	// Random pairs: mostly geometric, with collinear and parallel shapes and raw noise.
	task automatic push_random(int count);
		longint span, x1, y1, dx, dy, k3, k4, ox, oy;
		int mode;
		repeat (count) begin
			mode = $urandom_range(0, 9);
			span = ($urandom_range(0, 7) == 0) ? (64'd1 << 30) : 8 * UNIT;
			x1 = pick(span); y1 = pick(span);
			dx = pick(4 * UNIT); dy = pick(4 * UNIT);
			if ($urandom_range(0, 2) == 0) begin
				dx = dx & ~(UNIT - 1); dy = dy & ~(UNIT - 1);
			end
			k3 = pick(3); k4 = pick(3);
			case (mode)
				0, 1: push_pair({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
				2, 3: push_pair(from_points(x1, y1, x1 + 2*dx, y1 + 2*dy,
					x1 + k3*dx, y1 + k3*dy, x1 + k4*dx, y1 + k4*dy));
				4: begin
					ox = pick(UNIT); oy = pick(UNIT);
					push_pair(from_points(x1, y1, x1 + 2*dx, y1 + 2*dy, x1 + k3*dx + ox,
						y1 + k3*dy + oy, x1 + (k3 + 2)*dx + ox, y1 + (k3 + 2)*dy + oy));
				end
				default: push_pair(from_points(x1, y1, x1 + dx, y1 + dy, pick(span), pick(span),
					pick(span), pick(span)));
			endcase
		end
	endtask

	// Driver: presents one word per accepted start and updates the scale between phases.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cfg_wr_en <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_words.push_back(staged_word);
				n_accepted++;
			end
			if (start && busy) begin
				cfg_wr_en <= 1'b0;
			end else if (gap != 0) begin
				gap--;
				start <= 1'b0;
				cfg_wr_en <= 1'b0;
			end else if (work_queue.size() == 0) begin
				start <= 1'b0;
				cfg_wr_en <= 1'b0;
			end else if (work_queue[0].kind == ITEM_PAIR) begin
				pair_q <= work_queue[0].pair;
				staged_word = predict_crossing(work_queue[0].pair, scale_now);
				work_queue.pop_front();
				start <= 1'b1;
				cfg_wr_en <= 1'b0;
				// Occasional stretches with no gaps between words.
				if (calm != 0) begin
					calm--;
					gap = 0;
				end else begin
					if ($urandom_range(0, 15) == 0)
						calm = $urandom_range(10, 30);
					gap = $urandom_range(0, 11);
				end
			end else begin
				// Hold off until the pipeline has drained for a full latency.
				start <= 1'b0;
				settle = (expected_words.size() == 0 && !start) ? settle + 1 : 0;
				cfg_wr_en <= settle >= SETTLE_CYCLES && work_queue[0].kind == ITEM_SCALE;
				if (settle >= SETTLE_CYCLES) begin
					if (work_queue[0].kind == ITEM_SCALE) begin
						cfg_wr_data <= work_queue[0].scale;
						scale_now = work_queue[0].scale;
						n_scales++;
					end
					work_queue.pop_front();
					settle = 0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at word %0d: %s got 0x%0h expected 0x%0h", n_checked, what, got, want);
		errors++;
	endtask

	// Monitor: every done word is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				head_word = expected_words.pop_front();
				if (hit !== head_word.hit)
					report_mismatch("hit", hit, head_word.hit);
				if (t_first !== head_word.t1)
					report_mismatch("t_first", t_first, head_word.t1);
				if (t_second !== head_word.t2)
					report_mismatch("t_second", t_second, head_word.t2);
				if (relation !== head_word.rel)
					report_mismatch("relation", relation, head_word.rel);
				if (divide_fault !== head_word.fault)
					report_mismatch("divide_fault", divide_fault, head_word.fault);
				n_hits += head_word.hit;
			end
			n_checked++;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("segment_intersection_params regression: fail");
			$finish;
		end
	end

	// Stimulus plan and end of run.
	initial begin
		push_directed();
		push_random(200);
		push_scale(31'd0);
		push_directed();
		push_random(60);
		work_queue.push_back('{kind: ITEM_DRAIN, pair: '0, scale: '0});
		push_random(20);
		push_scale(31'h7FFF_FFFF);
		push_random(40);
		push_scale(31'($urandom_range(1, 1 << 20)));
		push_random(100);
		push_scale(sip_pkg::DS_RESET);
		push_random(60);
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (work_queue.size() != 0 || start || expected_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		$display("covered %0d segment pairs, %0d results checked (%0d hits), %0d scale settings",
			n_accepted, n_checked, n_hits, n_scales + 1);
		if (errors == 0) begin
			$display("segment_intersection_params regression: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("segment_intersection_params regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
